[hdl/environment_variable_store_assert.svh]
// Assertion helpers for the environment variable store.
`ifndef ENVIRONMENT_VARIABLE_STORE_ASSERT_SVH
`define ENVIRONMENT_VARIABLE_STORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define EVS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Next-cycle implication, checked out of reset.
`define EVS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/evs_pkg.sv]
`default_nettype none
package evs_pkg;

  localparam int OPC_W   = 3;
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 12;
  localparam int STAT_W  = 3;

  // opcodes
  localparam logic [OPC_W-1:0] OP_NAME  = 3'd0;
  localparam logic [OPC_W-1:0] OP_VALUE = 3'd1;
  localparam logic [OPC_W-1:0] OP_GET   = 3'd2;
  localparam logic [OPC_W-1:0] OP_SET   = 3'd3;
  localparam logic [OPC_W-1:0] OP_READ  = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STAT_W-1:0] ST_TRUNCATED = 3'd2;
  localparam logic [STAT_W-1:0] ST_NO_SPACE  = 3'd3;
  localparam logic [STAT_W-1:0] ST_TOO_LONG  = 3'd4;

  // characters
  localparam logic [BYTE_W-1:0] CH_EQ      = 8'h3d;
  localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LOWER_Z = 8'h7a;
  localparam logic [BYTE_W-1:0] CASE_DIFF  = 8'h20;

  function automatic logic [BYTE_W-1:0] upcase(input logic [BYTE_W-1:0] c);
    return (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c - CASE_DIFF : c;
  endfunction

endpackage
`default_nettype wire

[hdl/evs_cmd_if.sv]
`default_nettype none
interface evs_cmd_if;
  import evs_pkg::*;
  logic              valid;
  logic              ready;
  logic [OPC_W-1:0]  opcode;
  logic [BYTE_W-1:0] data_byte;
  logic [LEN_W-1:0]  buffer_length;
  modport source(output valid, opcode, data_byte, buffer_length, input ready);
  modport sink(input valid, opcode, data_byte, buffer_length, output ready);
endinterface
`default_nettype wire

[hdl/evs_rsp_if.sv]
`default_nettype none
interface evs_rsp_if;
  import evs_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [BYTE_W-1:0] value_byte;
  logic              byte_valid;
  logic [LEN_W-1:0]  copied_count;
  modport source(output valid, status, value_byte, byte_valid, copied_count, input ready);
  modport sink(input valid, status, value_byte, byte_valid, copied_count, output ready);
endinterface
`default_nettype wire

[hdl/environment_variable_store.sv]
// Environment variable store: NAME=value entries in a STORE_BYTES byte RAM,
// with a STAGE_BYTES staging RAM for name and value bytes. Every command gives
// one result. After reset the store RAM is zeroed by a clearing pass over all
// STORE_BYTES bytes, during which no command is taken. Get and set walk the
// store RAM a byte at a time: the lookup walks store bytes up to the used
// length, then get reads the value bytes; set moves each byte from the
// removed entry to the end of the used area, then appends the new entry.
// A finished result waits in the output register while the next command is
// taken.
`default_nettype none
`include "environment_variable_store_assert.svh"
module environment_variable_store #(
  parameter int STORE_BYTES = 2048,
  parameter int STAGE_BYTES = 256
) (
  input  wire logic clk,
  input  wire logic rst,
  evs_cmd_if.sink   cmd,
  evs_rsp_if.source rsp
);
  import evs_pkg::*;

  localparam int AW  = $clog2(STORE_BYTES);
  localparam int SAW = $clog2(STAGE_BYTES);
  localparam int SW  = $clog2(STAGE_BYTES + 1);
  localparam int QW  = $clog2(STAGE_BYTES + 4);
  localparam int PW  = $clog2(STORE_BYTES + STAGE_BYTES + 4) + 1;

  typedef enum logic [15:0] {
    S_IDLE      = 16'h0001,
    S_CLEAR     = 16'h0002,
    S_SCAN_RD   = 16'h0004,
    S_SCAN_CMP  = 16'h0008,
    S_VAL_RD    = 16'h0010,
    S_VAL_CHK   = 16'h0020,
    S_END_RD    = 16'h0040,
    S_END_CHK   = 16'h0080,
    S_MOV_RD    = 16'h0100,
    S_MOV_WR    = 16'h0200,
    S_APP_CHK   = 16'h0400,
    S_APP_RD    = 16'h0800,
    S_APP_WR    = 16'h1000,
    S_BYTE_RD   = 16'h2000,
    S_BYTE_DATA = 16'h4000,
    S_DONE      = 16'h8000
  } state_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] value_byte;
    logic              byte_valid;
    logic [LEN_W-1:0]  copied_count;
  } result_t;

  state_t            state;
  logic [AW-1:0]     tail;     // index of the final zero
  logic [AW-1:0]     pos;
  logic [SW-1:0]     k;
  logic              mok;
  logic [AW-1:0]     ent_at;
  logic [AW:0]       gap;
  logic [AW-1:0]     dst;
  logic [AW:0]       src;
  logic [QW-1:0]     q;
  logic [LEN_W-1:0]  cnt;
  logic [LEN_W-1:0]  len;
  logic [AW-1:0]     vstart;
  logic [AW-1:0]     raddr;
  logic [LEN_W-1:0]  rem;
  logic [SW-1:0]     n;
  logic [SW-1:0]     vc;
  logic              ovf;
  logic              is_set;
  logic              is_cmd;
  result_t           res;

  // memories
  logic [BYTE_W-1:0] env_mem [STORE_BYTES];
  logic [BYTE_W-1:0] stage_mem [STAGE_BYTES];
  logic [BYTE_W-1:0] env_rd;
  logic [BYTE_W-1:0] st_rd;
  logic              env_we;
  logic [AW-1:0]     env_wa;
  logic [AW-1:0]     env_ra;
  logic [BYTE_W-1:0] env_wd;
  logic              st_we;
  logic [SAW-1:0]    st_wa;
  logic [SAW-1:0]    st_ra;

  logic              acc;
  logic              s_clr;
  logic [SW-1:0]     n_eff;
  logic [SW-1:0]     v_eff;
  logic [SW:0]       tot;
  logic              full;
  logic              stage_op;
  logic [BYTE_W-1:0] app_byte;
  logic [QW-1:0]     app_last;
  logic [PW-1:0]     need;
  logic              hit;
  logic              name_fail;

  assign cmd.ready = (state == S_IDLE);
  assign acc       = cmd.valid && cmd.ready;

  // staging write decode
  always_comb begin
    stage_op = (cmd.opcode == OP_NAME) || (cmd.opcode == OP_VALUE);
    s_clr    = (cmd.opcode == OP_NAME) && (vc != '0);
    n_eff    = s_clr ? '0 : n;
    v_eff    = s_clr ? '0 : vc;
    tot      = {1'b0, n_eff} + {1'b0, v_eff};
    full     = tot >= (SW+1)'(STAGE_BYTES);
    st_we    = acc && stage_op && (cmd.data_byte != '0) && !full;
    st_wa    = tot[SAW-1:0];
  end

  // append byte and sizes
  always_comb begin
    app_last = QW'(n) + QW'(vc) + QW'(2);
    need     = PW'(n) + PW'(vc) + PW'(3);
    if (q < QW'(n)) app_byte = st_rd;
    else if (q == QW'(n)) app_byte = CH_EQ;
    else if (q < QW'(n) + QW'(vc) + QW'(1)) app_byte = st_rd;
    else app_byte = '0;
  end

  // name compare
  always_comb begin
    hit       = mok && (k == n) && (env_rd == CH_EQ);
    name_fail = (env_rd == '0) || (env_rd == CH_EQ) || (upcase(env_rd) != upcase(st_rd));
  end

  // memory port selection
  always_comb begin
    env_we = 1'b0;
    env_wa = dst;
    env_wd = '0;
    env_ra = pos;
    st_ra  = k[SAW-1:0];
    case (state)
      S_CLEAR: begin
        env_we = 1'b1;
        env_wa = pos;
      end
      S_MOV_RD: env_ra = src[AW-1:0];
      S_MOV_WR: begin
        env_we = 1'b1;
        env_wd = (src <= {1'b0, tail}) ? env_rd : '0;
      end
      S_APP_RD: st_ra = (q < QW'(n)) ? q[SAW-1:0] : SAW'(q - QW'(1));
      S_APP_WR: begin
        env_we = 1'b1;
        env_wa = tail + AW'(q);
        env_wd = app_byte;
      end
      S_BYTE_RD: env_ra = raddr;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (env_we) env_mem[env_wa] <= env_wd;
    env_rd <= env_mem[env_ra];
  end

  always_ff @(posedge clk) begin
    if (st_we) stage_mem[st_wa] <= cmd.data_byte;
    st_rd <= stage_mem[st_ra];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      pos       <= '0;
      tail      <= '0;
      n         <= '0;
      vc        <= '0;
      ovf       <= 1'b0;
      rem       <= '0;
      raddr     <= '0;
      is_cmd    <= 1'b0;
      is_set    <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_DONE) rsp.valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          if (pos == AW'(STORE_BYTES - 1)) state <= S_IDLE;
          else pos <= pos + AW'(1);
        end
        S_IDLE: begin
          if (acc) begin
            pos    <= '0;
            ent_at <= '0;
            k      <= '0;
            mok    <= 1'b1;
            if (cmd.opcode == OP_GET || cmd.opcode == OP_SET) begin
              is_cmd               <= 1'b1;
              is_set               <= (cmd.opcode == OP_SET);
              len                  <= cmd.buffer_length;
              rem                  <= '0;
              res.value_byte       <= '0;
              res.byte_valid       <= 1'b0;
              res.copied_count     <= '0;
              if (ovf) begin
                res.status <= ST_TOO_LONG;
                state      <= S_DONE;
              end else if (tail == '0) begin
                if (cmd.opcode == OP_SET) begin
                  res.status <= ST_OK;
                  state      <= S_APP_CHK;
                end else begin
                  res.status <= ST_NOT_FOUND;
                  state      <= S_DONE;
                end
              end else begin
                res.status <= ST_OK;
                state      <= S_SCAN_RD;
              end
            end else begin
              res    <= '0;
              is_cmd <= 1'b0;
              if (cmd.opcode == OP_READ && rem != '0) state <= S_BYTE_RD;
              else state <= S_DONE;
              // stage a byte; a name byte after value bytes restarts staging
              if (stage_op) begin
                n   <= (st_we && cmd.opcode == OP_NAME) ? n_eff + SW'(1) : n_eff;
                vc  <= (st_we && cmd.opcode == OP_VALUE) ? v_eff + SW'(1) : v_eff;
                ovf <= ((cmd.data_byte != '0) && full) || (ovf && !s_clr);
              end
            end
          end
        end
        S_SCAN_RD: state <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (hit) begin
            pos    <= pos + AW'(1);
            vstart <= pos + AW'(1);
            cnt    <= '0;
            state  <= is_set ? S_END_RD : S_VAL_RD;
          end else if (env_rd == '0) begin
            if (({1'b0, pos} + 1'b1) < {1'b0, tail}) begin
              pos    <= pos + AW'(1);
              ent_at <= pos + AW'(1);
              k      <= '0;
              mok    <= 1'b1;
              state  <= S_SCAN_RD;
            end else if (is_set) state <= S_APP_CHK;
            else begin
              res.status <= ST_NOT_FOUND;
              state      <= S_DONE;
            end
          end else begin
            if (mok) begin
              if (k < n) begin
                if (name_fail) mok <= 1'b0;
                k <= k + SW'(1);
              end else mok <= 1'b0;
            end
            pos   <= pos + AW'(1);
            state <= S_SCAN_RD;
          end
        end
        S_VAL_RD: state <= S_VAL_CHK;
        S_VAL_CHK: begin
          if (env_rd == '0 || ({1'b0, cnt} + 1'b1) >= {1'b0, len}) begin
            res.status       <= (env_rd == '0) ? ST_OK : ST_TRUNCATED;
            res.copied_count <= cnt;
            raddr            <= vstart;
            rem              <= cnt;
            state            <= S_DONE;
          end else begin
            cnt   <= cnt + LEN_W'(1);
            pos   <= pos + AW'(1);
            state <= S_VAL_RD;
          end
        end
        S_END_RD: state <= S_END_CHK;
        S_END_CHK: begin
          if (env_rd == '0) begin
            gap   <= {1'b0, pos} + 1'b1 - {1'b0, ent_at};
            dst   <= ent_at;
            src   <= {1'b0, pos} + 1'b1;
            state <= S_MOV_RD;
          end else begin
            pos   <= pos + AW'(1);
            state <= S_END_RD;
          end
        end
        S_MOV_RD: state <= S_MOV_WR;
        S_MOV_WR: begin
          if (dst == tail) begin
            tail  <= AW'({1'b0, tail} - gap);
            state <= S_APP_CHK;
          end else begin
            dst   <= dst + AW'(1);
            src   <= src + 1'b1;
            state <= S_MOV_RD;
          end
        end
        S_APP_CHK: begin
          q     <= '0;
          state <= S_DONE;
          if (vc != '0) begin
            if (PW'(tail) + need > PW'(STORE_BYTES)) res.status <= ST_NO_SPACE;
            else state <= S_APP_RD;
          end
        end
        S_APP_RD: state <= S_APP_WR;
        S_APP_WR: begin
          if (q == app_last) begin
            tail  <= tail + AW'(app_last);
            state <= S_DONE;
          end else begin
            q     <= q + QW'(1);
            state <= S_APP_RD;
          end
        end
        S_BYTE_RD: state <= S_BYTE_DATA;
        S_BYTE_DATA: begin
          res.value_byte <= env_rd;
          res.byte_valid <= 1'b1;
          raddr          <= raddr + AW'(1);
          rem            <= rem - LEN_W'(1);
          state          <= S_DONE;
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid        <= 1'b1;
            rsp.status       <= res.status;
            rsp.value_byte   <= res.value_byte;
            rsp.byte_valid   <= res.byte_valid;
            rsp.copied_count <= res.copied_count;
            if (is_cmd) begin
              n   <= '0;
              vc  <= '0;
              ovf <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `EVS_ASSERT(a_byte_only_on_read, rsp.valid && rsp.byte_valid |-> rsp.status == ST_OK && rsp.copied_count == '0, "byte delivered with status or count")
  `EVS_ASSERT(a_move_forward, state == S_MOV_WR |-> src > {1'b0, dst}, "compaction source not ahead of destination")
  `EVS_ASSERT(a_append_fits, state == S_APP_WR |-> (PW'(tail) + PW'(q)) < PW'(STORE_BYTES), "append beyond store")
  `EVS_ASSERT_NEXT(a_read_count, state == S_BYTE_DATA, rem == LEN_W'($past(rem) - 1'b1), "pending read count not decremented")

endmodule
`default_nettype wire
